FILE: rtl/lbpc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Lidar beam point correction package
// Shared types, sizes and constants for the point correction pipeline.
// ---------------------------------------------------------------------------
package lbpc_pkg;

    localparam int NUM_BEAMS = 64;
    localparam int BEAM_W    = 6;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_POINT = 1'b1;

    localparam logic [15:0] AZ_FULL    = 16'd36000;
    localparam logic [15:0] AZ_HALF    = 16'd18000;
    localparam logic [15:0] AZ_3Q      = 16'd27000;
    localparam logic [15:0] AZ_QUARTER = 16'd9000;

    // Radians per hundredth of a degree in Q0.40.
    localparam logic [41:0] K40   = 42'd191900981;
    localparam logic [30:0] ONE30 = 31'h4000_0000;

    localparam int TAYLOR_STEPS = 6;
    localparam logic [7:0] TAYLOR_DIV [TAYLOR_STEPS] = '{
        8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };
    localparam logic [31:0] TAYLOR_RECIP [TAYLOR_STEPS] = '{
        32'((64'd1 << 34) / 64'd156), 32'((64'd1 << 34) / 64'd110),
        32'((64'd1 << 34) / 64'd72),  32'((64'd1 << 34) / 64'd42),
        32'((64'd1 << 34) / 64'd20),  32'((64'd1 << 34) / 64'd6)
    };

    localparam int SIN_LAT  = 2 + 3 * TAYLOR_STEPS + 2;
    localparam int GEOM_LAT = 5;
    localparam int VLD_LEN  = 1 + SIN_LAT + GEOM_LAT;

    localparam logic signed [19:0] OUT_MAX = 20'sd524287;
    localparam logic signed [19:0] OUT_MIN = -20'sd524288;

    typedef enum logic [1:0] {
        Q_FIRST,
        Q_SECOND,
        Q_THIRD,
        Q_FOURTH
    } t_quad;

    typedef struct packed {
        logic signed [15:0] horiz;
        logic signed [15:0] vert;
        logic signed [15:0] dist_corr;
        logic signed [15:0] rot_sin;
        logic signed [15:0] rot_cos;
        logic signed [15:0] vert_sin;
        logic signed [15:0] vert_cos;
    } t_cal_entry;

    typedef struct packed {
        logic signed [19:0] origin_x;
        logic signed [19:0] origin_y;
        logic signed [19:0] origin_z;
        logic signed [19:0] point_x;
        logic signed [19:0] point_y;
        logic signed [19:0] point_z;
        logic               saturated;
    } t_point;

    // Drops 15 fraction bits, rounding half up.
    function automatic logic signed [32:0] f_rnd15(input logic signed [47:0] v);
        logic signed [47:0] w;
        w = v + 48'sd16384;
        return 33'(w >>> 15);
    endfunction

    function automatic logic signed [19:0] f_clamp20(input logic signed [25:0] v);
        logic signed [19:0] res;
        if (v > 26'(OUT_MAX)) begin
            res = OUT_MAX;
        end else if (v < 26'(OUT_MIN)) begin
            res = OUT_MIN;
        end else begin
            res = 20'(v);
        end
        return res;
    endfunction

    function automatic logic f_out20(input logic signed [25:0] v);
        return (v > 26'(OUT_MAX)) || (v < 26'(OUT_MIN));
    endfunction

endpackage
`default_nettype wire

FILE: rtl/lbpc_cal_mem.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Calibration table memory
// Offset and angle tables, one write port and one registered read port each.
// ---------------------------------------------------------------------------
module lbpc_cal_mem import lbpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [BEAM_W-1:0] i_wr_addr,
    input  t_cal_entry        i_wr_data,
    input  logic              i_rd_en,
    input  logic [BEAM_W-1:0] i_rd_addr,
    output t_cal_entry        o_rd_data
);

    logic [47:0] r_off_mem [NUM_BEAMS];
    logic [63:0] r_ang_mem [NUM_BEAMS];
    logic [47:0] r_rd_off;
    logic [63:0] r_rd_ang;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_off_mem[i_wr_addr] <= {i_wr_data.dist_corr, i_wr_data.vert, i_wr_data.horiz};
            r_ang_mem[i_wr_addr] <= {i_wr_data.vert_cos, i_wr_data.vert_sin,
                                     i_wr_data.rot_cos, i_wr_data.rot_sin};
        end
        if (i_rd_en) begin
            r_rd_off <= r_off_mem[i_rd_addr];
            r_rd_ang <= r_ang_mem[i_rd_addr];
        end
    end

    assign o_rd_data.horiz     = r_rd_off[15:0];
    assign o_rd_data.vert      = r_rd_off[31:16];
    assign o_rd_data.dist_corr = r_rd_off[47:32];
    assign o_rd_data.rot_sin   = r_rd_ang[15:0];
    assign o_rd_data.rot_cos   = r_rd_ang[31:16];
    assign o_rd_data.vert_sin  = r_rd_ang[47:32];
    assign o_rd_data.vert_cos  = r_rd_ang[63:48];

endmodule
`default_nettype wire

FILE: rtl/lbpc_sine.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Quarter-wave sine unit
// Pipelined Taylor evaluation of the Q1.15 sine for 0 to 90.00 degrees.
// ---------------------------------------------------------------------------
module lbpc_sine import lbpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [13:0] i_cdeg,
    output logic [15:0] o_sin
);

    logic [41:0] w_xprod;
    logic [61:0] w_xsq;
    logic [61:0] w_sprod;
    logic [16:0] w_srnd;
    logic [30:0] r_x_s1;
    logic [30:0] r_x_s2;
    logic [31:0] r_xsq_s2;
    logic [30:0] r_ax  [TAYLOR_STEPS];
    logic [31:0] r_ax2 [TAYLOR_STEPS];
    logic [31:0] r_ap  [TAYLOR_STEPS];
    logic [30:0] r_bx  [TAYLOR_STEPS];
    logic [31:0] r_bx2 [TAYLOR_STEPS];
    logic [31:0] r_bp  [TAYLOR_STEPS];
    logic [29:0] r_bq  [TAYLOR_STEPS];
    logic [30:0] r_cx  [TAYLOR_STEPS];
    logic [31:0] r_cx2 [TAYLOR_STEPS];
    logic [30:0] r_ct  [TAYLOR_STEPS];
    logic [31:0] r_s;
    logic [15:0] r_sin;

    assign w_xprod = 42'(i_cdeg) * K40;
    assign w_xsq   = 62'(r_x_s1) * 62'(r_x_s1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x_s1   <= w_xprod[40:10];
            r_x_s2   <= r_x_s1;
            r_xsq_s2 <= w_xsq[61:30];
        end
    end

    for (genvar gi = 0; gi < TAYLOR_STEPS; gi++) begin : g_step
        logic [30:0] w_x_in;
        logic [31:0] w_x2_in;
        logic [30:0] w_t_in;
        logic [63:0] w_prod_p;
        logic [63:0] w_prod_q;
        logic [32:0] w_rem;
        logic [29:0] w_q;

        if (gi == 0) begin : g_first
            assign w_x_in  = r_x_s2;
            assign w_x2_in = r_xsq_s2;
            assign w_t_in  = ONE30;
        end else begin : g_next
            assign w_x_in  = r_cx[gi-1];
            assign w_x2_in = r_cx2[gi-1];
            assign w_t_in  = r_ct[gi-1];
        end

        assign w_prod_p = 64'(w_x2_in) * 64'(w_t_in);
        assign w_prod_q = 64'(r_ap[gi]) * 64'(TAYLOR_RECIP[gi]);
        assign w_rem    = 33'(r_bp[gi]) - 33'(r_bq[gi]) * 33'(TAYLOR_DIV[gi]);
        assign w_q      = (w_rem >= 33'(TAYLOR_DIV[gi])) ? r_bq[gi] + 30'd1 : r_bq[gi];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ax[gi]  <= w_x_in;
                r_ax2[gi] <= w_x2_in;
                r_ap[gi]  <= w_prod_p[61:30];
                r_bx[gi]  <= r_ax[gi];
                r_bx2[gi] <= r_ax2[gi];
                r_bp[gi]  <= r_ap[gi];
                r_bq[gi]  <= w_prod_q[63:34];
                r_cx[gi]  <= r_bx[gi];
                r_cx2[gi] <= r_bx2[gi];
                r_ct[gi]  <= ONE30 - 31'(w_q);
            end
        end
    end

    assign w_sprod = 62'(r_cx[TAYLOR_STEPS-1]) * 62'(r_ct[TAYLOR_STEPS-1]);
    assign w_srnd  = 17'((33'(r_s) + 33'd16384) >> 15);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s   <= w_sprod[61:30];
            r_sin <= (w_srnd > 17'd32767) ? 16'd32767 : w_srnd[15:0];
        end
    end

    assign o_sin = r_sin;

endmodule
`default_nettype wire

FILE: rtl/lbpc_geom.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Point geometry pipeline
// Rotates the azimuth by the beam correction and forms origin and hit point.
// ---------------------------------------------------------------------------
module lbpc_geom import lbpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_sin,
    input  logic signed [15:0] i_cos,
    input  logic        [17:0] i_range,
    input  t_cal_entry         i_cal,
    output t_point             o_pt
);

    logic signed [31:0] r_m1, r_m2, r_m3, r_m4, r_m5, r_m6;
    logic signed [19:0] r_d1;
    logic signed [15:0] r_h1, r_vs1, r_vc1;

    logic signed [17:0] r_cc2, r_cs2;
    logic signed [16:0] r_vxy2, r_oz2;
    logic signed [35:0] r_dvc2, r_dvs2;
    logic signed [15:0] r_h2;

    logic signed [20:0] r_dxy3, r_pzr3;
    logic signed [33:0] r_hcs3, r_hcc3;
    logic signed [34:0] r_vcc3, r_vcs3;
    logic signed [17:0] r_cc3, r_cs3;
    logic signed [16:0] r_oz3;

    logic signed [20:0] r_ox4, r_oy4, r_pzr4;
    logic signed [38:0] r_dcc4, r_dcs4;
    logic signed [16:0] r_oz4;

    logic signed [25:0] w_v [6];
    t_point             r_pt;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1  <= i_cos * i_cal.rot_cos;
            r_m2  <= i_sin * i_cal.rot_sin;
            r_m3  <= i_sin * i_cal.rot_cos;
            r_m4  <= i_cos * i_cal.rot_sin;
            r_m5  <= i_cal.vert * i_cal.vert_sin;
            r_m6  <= i_cal.vert * i_cal.vert_cos;
            r_d1  <= $signed({2'b00, i_range}) + 20'(i_cal.dist_corr);
            r_h1  <= i_cal.horiz;
            r_vs1 <= i_cal.vert_sin;
            r_vc1 <= i_cal.vert_cos;

            r_cc2  <= 18'(f_rnd15(48'(r_m1) - 48'(r_m2)));
            r_cs2  <= 18'(f_rnd15(48'(r_m3) + 48'(r_m4)));
            r_vxy2 <= 17'(f_rnd15(48'(r_m5)));
            r_oz2  <= 17'(f_rnd15(48'(r_m6)));
            r_dvc2 <= r_d1 * r_vc1;
            r_dvs2 <= r_d1 * r_vs1;
            r_h2   <= r_h1;

            r_dxy3 <= 21'(f_rnd15(48'(r_dvc2)));
            r_pzr3 <= 21'(f_rnd15(48'(r_dvs2)));
            r_hcs3 <= r_h2 * r_cs2;
            r_hcc3 <= r_h2 * r_cc2;
            r_vcc3 <= r_vxy2 * r_cc2;
            r_vcs3 <= r_vxy2 * r_cs2;
            r_cc3  <= r_cc2;
            r_cs3  <= r_cs2;
            r_oz3  <= r_oz2;

            r_ox4  <= 21'(f_rnd15(-48'(r_hcs3) - 48'(r_vcc3)));
            r_oy4  <= 21'(f_rnd15(48'(r_hcc3) - 48'(r_vcs3)));
            r_dcc4 <= r_dxy3 * r_cc3;
            r_dcs4 <= r_dxy3 * r_cs3;
            r_pzr4 <= r_pzr3;
            r_oz4  <= r_oz3;

            r_pt.origin_x  <= f_clamp20(w_v[0]);
            r_pt.origin_y  <= f_clamp20(w_v[1]);
            r_pt.origin_z  <= f_clamp20(w_v[2]);
            r_pt.point_x   <= f_clamp20(w_v[3]);
            r_pt.point_y   <= f_clamp20(w_v[4]);
            r_pt.point_z   <= f_clamp20(w_v[5]);
            r_pt.saturated <= f_out20(w_v[0]) || f_out20(w_v[1]) || f_out20(w_v[2])
                           || f_out20(w_v[3]) || f_out20(w_v[4]) || f_out20(w_v[5]);
        end
    end

    assign w_v[0] = 26'(r_ox4);
    assign w_v[1] = 26'(r_oy4);
    assign w_v[2] = 26'(r_oz4);
    assign w_v[3] = 26'(f_rnd15(48'(r_dcc4))) + 26'(r_ox4);
    assign w_v[4] = 26'(f_rnd15(48'(r_dcs4))) + 26'(r_oy4);
    assign w_v[5] = 26'(r_pzr4) + 26'(r_oz4);

    assign o_pt = r_pt;

endmodule
`default_nettype wire

FILE: rtl/lidar_beam_point_correction.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Lidar beam point correction
// Loads per-beam calibration entries and turns lidar returns into corrected
// beam origins and hit points in millimeters.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake          Carries
//  input     in         i_valid / o_stall  load entry or return request
//  output    out        o_valid / i_stall  origin, point, saturated flag
//
//  One request is accepted per cycle while the output is not stalled.
//  A return passes the input register and calibration read, the 22-stage
//  sine pipeline and five geometry stages. Load requests give no result.
//  Reset clears only the valid bits; the calibration memories are not cleared.
//  A stalled output freezes the whole pipeline and stalls the input.
// ---------------------------------------------------------------------------
module lidar_beam_point_correction import lbpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic [5:0]         i_beam_index,
    input  logic [17:0]        i_range_mm,
    input  logic [15:0]        i_azimuth_cdeg,
    input  logic signed [15:0] i_horiz_offset_mm,
    input  logic signed [15:0] i_vert_offset_mm,
    input  logic signed [15:0] i_dist_corr_mm,
    input  logic signed [15:0] i_rot_sin,
    input  logic signed [15:0] i_rot_cos,
    input  logic signed [15:0] i_vert_sin,
    input  logic signed [15:0] i_vert_cos,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [19:0] o_origin_x,
    output logic signed [19:0] o_origin_y,
    output logic signed [19:0] o_origin_z,
    output logic signed [19:0] o_point_x,
    output logic signed [19:0] o_point_y,
    output logic signed [19:0] o_point_z,
    output logic               o_saturated
);

    logic        w_en;
    logic        w_accept;
    logic        w_beam_ok;
    t_cal_entry  w_wr_data;
    t_cal_entry  w_cal_rd;
    logic [15:0] w_az;
    logic [15:0] w_rem;
    t_quad       w_quad;
    logic [15:0] w_s1;
    logic [15:0] w_s2;
    logic signed [15:0] w_sin;
    logic signed [15:0] w_cos;
    t_point      w_pt;

    logic        r_vld      [VLD_LEN];
    t_quad       r_s0_quad;
    logic [13:0] r_s0_rem;
    logic [17:0] r_s0_range;
    t_quad       r_dl_quad  [SIN_LAT];
    logic [17:0] r_dl_range [SIN_LAT];
    t_cal_entry  r_dl_cal   [SIN_LAT];

    assign w_en      = !r_vld[VLD_LEN-1] || !i_stall;
    assign o_stall   = !w_en;
    assign w_accept  = i_valid && w_en;
    assign w_beam_ok = (9'(i_beam_index) < 9'(NUM_BEAMS));

    assign w_wr_data.horiz     = i_horiz_offset_mm;
    assign w_wr_data.vert      = i_vert_offset_mm;
    assign w_wr_data.dist_corr = i_dist_corr_mm;
    assign w_wr_data.rot_sin   = i_rot_sin;
    assign w_wr_data.rot_cos   = i_rot_cos;
    assign w_wr_data.vert_sin  = i_vert_sin;
    assign w_wr_data.vert_cos  = i_vert_cos;

    lbpc_cal_mem u_cal_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && (i_mode == MODE_LOAD) && w_beam_ok),
        .i_wr_addr (i_beam_index),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_en),
        .i_rd_addr (i_beam_index),
        .o_rd_data (w_cal_rd)
    );

    always_comb begin
        w_az = (i_azimuth_cdeg >= AZ_FULL) ? i_azimuth_cdeg - AZ_FULL : i_azimuth_cdeg;
        if (w_az >= AZ_3Q) begin
            w_quad = Q_FOURTH;
            w_rem  = w_az - AZ_3Q;
        end else if (w_az >= AZ_HALF) begin
            w_quad = Q_THIRD;
            w_rem  = w_az - AZ_HALF;
        end else if (w_az >= AZ_QUARTER) begin
            w_quad = Q_SECOND;
            w_rem  = w_az - AZ_QUARTER;
        end else begin
            w_quad = Q_FIRST;
            w_rem  = w_az;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VLD_LEN; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= w_accept && (i_mode == MODE_POINT) && w_beam_ok;
            for (int i = 1; i < VLD_LEN; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_quad     <= w_quad;
            r_s0_rem      <= w_rem[13:0];
            r_s0_range    <= i_range_mm;
            r_dl_quad[0]  <= r_s0_quad;
            r_dl_range[0] <= r_s0_range;
            r_dl_cal[0]   <= w_cal_rd;
            for (int i = 1; i < SIN_LAT; i++) begin
                r_dl_quad[i]  <= r_dl_quad[i-1];
                r_dl_range[i] <= r_dl_range[i-1];
                r_dl_cal[i]   <= r_dl_cal[i-1];
            end
        end
    end

    lbpc_sine u_sine_r (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_cdeg (r_s0_rem),
        .o_sin  (w_s1)
    );

    lbpc_sine u_sine_c (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_cdeg (AZ_QUARTER[13:0] - r_s0_rem),
        .o_sin  (w_s2)
    );

    always_comb begin
        case (r_dl_quad[SIN_LAT-1])
            Q_FIRST: begin
                w_sin = $signed(w_s1);
                w_cos = $signed(w_s2);
            end
            Q_SECOND: begin
                w_sin = $signed(w_s2);
                w_cos = -$signed(w_s1);
            end
            Q_THIRD: begin
                w_sin = -$signed(w_s1);
                w_cos = -$signed(w_s2);
            end
            default: begin
                w_sin = -$signed(w_s2);
                w_cos = $signed(w_s1);
            end
        endcase
    end

    lbpc_geom u_geom (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_sin   (w_sin),
        .i_cos   (w_cos),
        .i_range (r_dl_range[SIN_LAT-1]),
        .i_cal   (r_dl_cal[SIN_LAT-1]),
        .o_pt    (w_pt)
    );

    assign o_valid     = r_vld[VLD_LEN-1];
    assign o_origin_x  = w_pt.origin_x;
    assign o_origin_y  = w_pt.origin_y;
    assign o_origin_z  = w_pt.origin_z;
    assign o_point_x   = w_pt.point_x;
    assign o_point_y   = w_pt.point_y;
    assign o_point_z   = w_pt.point_z;
    assign o_saturated = w_pt.saturated;

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_origin_x == OUT_MAX || o_origin_x == OUT_MIN ||
             o_origin_y == OUT_MAX || o_origin_y == OUT_MIN ||
             o_origin_z == OUT_MAX || o_origin_z == OUT_MIN ||
             o_point_x == OUT_MAX || o_point_x == OUT_MIN ||
             o_point_y == OUT_MAX || o_point_y == OUT_MIN ||
             o_point_z == OUT_MAX || o_point_z == OUT_MIN))
        else $error("saturated flag without a clamped coordinate");

endmodule
`default_nettype wire
